@@ src/abdd_pkg.sv @@
package abdd_pkg;

   localparam int EXP_TABLE_ENTRIES_DEF = 256;
   localparam int CSR_INDEX_W = 8;
   localparam int COORD_W = 16;
   localparam int DELTA_W = 16;
   localparam int SCALE_W = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_CENTER_Y = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_CENTER_X = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_HEIGHT   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_WIDTH    = 8'd3;

   localparam logic [SCALE_W-1:0] SCALE_CENTER_RESET = 16'd410;
   localparam logic [SCALE_W-1:0] SCALE_SIZE_RESET   = 16'd819;

   // Clamp on the scaled delta: plus or minus 10.0 in Q.23.
   localparam logic signed [27:0] CLAMP_Q23 = 28'sd83886080;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam longint LN2_Q30 = 64'sd744261118;
   localparam logic [16:0] COORD_ONE = 17'd32768;

   // Quotient of two nonnegative values by restoring long division.
   // Only evaluated while the constant table is elaborated.
   function automatic longint udiv(input longint num, input longint den);
      longint q;
      longint rem;
      q = 64'sd0;
      rem = 64'sd0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
         q = q <<< 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 64'sd1;
         end
      end
      return q;
   endfunction

   // One entry of the 2^(k/N) table in Q2.30, N = 2^lg, by a thirteen-term series.
   function automatic longint pow2_entry(input longint k, input int lg);
      longint x;
      longint term;
      longint sum;
      x = (k * LN2_Q30 + (64'sd1 <<< (lg - 1))) >>> lg;
      term = 64'sd1 <<< 30;
      sum = term;
      for (int i = 1; i <= 12; i++) begin
         term = udiv((term * x) >>> 30, longint'(i));
         sum = sum + term;
      end
      return sum;
   endfunction

endpackage

@@ src/anchor_box_delta_decode_top.sv @@
// Throughput: one box per cycle while the response is not stalled; the nine-stage
// pipeline advances stage by stage, so a stalled response holds only the unbroken run of full stages behind it.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// scale registers with their defaults. The exp table is constant logic.
module anchor_box_delta_decode_top #(
   parameter int EXP_TABLE_ENTRIES = abdd_pkg::EXP_TABLE_ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [abdd_pkg::COORD_W-1:0]          req_anchor_ymin,
   input  logic [abdd_pkg::COORD_W-1:0]          req_anchor_xmin,
   input  logic [abdd_pkg::COORD_W-1:0]          req_anchor_ymax,
   input  logic [abdd_pkg::COORD_W-1:0]          req_anchor_xmax,
   input  logic signed [abdd_pkg::DELTA_W-1:0]   req_delta_cy,
   input  logic signed [abdd_pkg::DELTA_W-1:0]   req_delta_cx,
   input  logic signed [abdd_pkg::DELTA_W-1:0]   req_delta_h,
   input  logic signed [abdd_pkg::DELTA_W-1:0]   req_delta_w,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [abdd_pkg::COORD_W-1:0]          rsp_out_ymin,
   output logic [abdd_pkg::COORD_W-1:0]          rsp_out_xmin,
   output logic [abdd_pkg::COORD_W-1:0]          rsp_out_ymax,
   output logic [abdd_pkg::COORD_W-1:0]          rsp_out_xmax,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [abdd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [abdd_pkg::SCALE_W-1:0]          csr_data
);

   localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
   localparam int NST = 9;

   typedef struct packed {
      logic signed [16:0] size;
      logic [16:0]        sum;
      logic signed [27:0] tc;
      logic signed [27:0] ts;
      logic signed [44:0] pc;
      logic signed [59:0] pu;
      logic signed [23:0] center;
      logic signed [5:0]  n;
      logic [IDX_W-1:0]   idx;
      logic [29:0]        r;
      logic [31:0]        lo;
      logic [31:0]        diff;
      logic [61:0]        dr;
      logic [32:0]        mant;
      logic signed [49:0] hp;
      logic signed [33:0] half;
      logic [15:0]        omin;
      logic [15:0]        omax;
   } axis_type;

   logic [31:0] pow2_tab [EXP_TABLE_ENTRIES+1];
   for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++) begin : g_tab
      localparam longint ENTRY = abdd_pkg::pow2_entry(k, IDX_W);
      assign pow2_tab[k] = ENTRY[31:0];
   end

   // Scale registers.
   logic [abdd_pkg::SCALE_W-1:0] scale_ff [4];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff[0] <= abdd_pkg::SCALE_CENTER_RESET;
         scale_ff[1] <= abdd_pkg::SCALE_CENTER_RESET;
         scale_ff[2] <= abdd_pkg::SCALE_SIZE_RESET;
         scale_ff[3] <= abdd_pkg::SCALE_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            abdd_pkg::REG_SCALE_CENTER_Y: scale_ff[0] <= csr_data;
            abdd_pkg::REG_SCALE_CENTER_X: scale_ff[1] <= csr_data;
            abdd_pkg::REG_SCALE_HEIGHT:   scale_ff[2] <= csr_data;
            abdd_pkg::REG_SCALE_WIDTH:    scale_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   logic [15:0]        amin [2];
   logic [15:0]        amax [2];
   logic signed [15:0] dc [2];
   logic signed [15:0] ds [2];
   logic [15:0]        sc [2];
   logic [15:0]        ss [2];

   assign amin[0] = req_anchor_ymin;
   assign amin[1] = req_anchor_xmin;
   assign amax[0] = req_anchor_ymax;
   assign amax[1] = req_anchor_xmax;
   assign dc[0] = req_delta_cy;
   assign dc[1] = req_delta_cx;
   assign ds[0] = req_delta_h;
   assign ds[1] = req_delta_w;
   assign sc[0] = scale_ff[0];
   assign sc[1] = scale_ff[1];
   assign ss[0] = scale_ff[2];
   assign ss[1] = scale_ff[3];

   axis_type   ax_ff [NST][2];
   axis_type   ax_in [NST][2];
   logic [NST-1:0] valid_ff;
   logic [NST:0]   en;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      en[NST] = !rsp_stall;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_comb begin
      logic signed [32:0] pcs;
      logic signed [32:0] pss;
      logic [44:0]        magc;
      logic [22:0]        rc;
      logic [59:0]        magu;
      logic [36:0]        ru;
      logic signed [35:0] u;
      logic [IDX_W:0]     idx0;
      logic [IDX_W:0]     idx1;
      logic [6:0]         sh;
      logic [49:0]        magh;
      logic [49:0]        rh;
      logic signed [34:0] va;
      logic signed [34:0] vb;
      logic [34:0]        ca;
      logic [34:0]        cb;
      logic [16:0]        oa;
      logic [16:0]        ob;
      for (int a = 0; a < 2; a++) begin
         // Stage 0: anchor size and center sum, scaled and clamped deltas.
         ax_in[0][a] = ax_ff[0][a];
         ax_in[0][a].size = $signed(17'(amax[a]) - 17'(amin[a]));
         ax_in[0][a].sum = 17'(amin[a]) + 17'(amax[a]);
         pcs = dc[a] * $signed({1'b0, sc[a]});
         pss = ds[a] * $signed({1'b0, ss[a]});
         if (pcs > 33'(abdd_pkg::CLAMP_Q23)) ax_in[0][a].tc = abdd_pkg::CLAMP_Q23;
         else if (pcs < -33'(abdd_pkg::CLAMP_Q23)) ax_in[0][a].tc = -abdd_pkg::CLAMP_Q23;
         else ax_in[0][a].tc = 28'(pcs);
         if (pss > 33'(abdd_pkg::CLAMP_Q23)) ax_in[0][a].ts = abdd_pkg::CLAMP_Q23;
         else if (pss < -33'(abdd_pkg::CLAMP_Q23)) ax_in[0][a].ts = -abdd_pkg::CLAMP_Q23;
         else ax_in[0][a].ts = 28'(pss);

         // Stage 1: center offset product and log2 conversion product.
         ax_in[1][a] = ax_ff[0][a];
         ax_in[1][a].pc = ax_ff[0][a].tc * ax_ff[0][a].size;
         ax_in[1][a].pu = ax_ff[0][a].ts * $signed({1'b0, abdd_pkg::LOG2E_Q30});

         // Stage 2: rounding, center, integer and fraction of the exponent.
         ax_in[2][a] = ax_ff[1][a];
         magc = ax_ff[1][a].pc[44] ? 45'(-ax_ff[1][a].pc) : 45'(ax_ff[1][a].pc);
         rc = 23'((magc + 45'(1 << 21)) >> 22);
         ax_in[2][a].center = ax_ff[1][a].pc[44] ?
            $signed(24'(ax_ff[1][a].sum)) - $signed({1'b0, rc}) :
            $signed(24'(ax_ff[1][a].sum)) + $signed({1'b0, rc});
         magu = ax_ff[1][a].pu[59] ? 60'(-ax_ff[1][a].pu) : 60'(ax_ff[1][a].pu);
         ru = 37'((magu + 60'(1 << 22)) >> 23);
         u = ax_ff[1][a].pu[59] ? -$signed(36'(ru)) : $signed(36'(ru));
         ax_in[2][a].n = u[35:30];
         ax_in[2][a].idx = u[29 -: IDX_W];
         ax_in[2][a].r = 30'(u[29-IDX_W:0]) << IDX_W;

         // Stage 3: table lookup.
         ax_in[3][a] = ax_ff[2][a];
         idx0 = {1'b0, ax_ff[2][a].idx};
         idx1 = idx0 + 1'b1;
         ax_in[3][a].lo = pow2_tab[idx0];
         ax_in[3][a].diff = pow2_tab[idx1] - pow2_tab[idx0];

         // Stage 4: interpolation product.
         ax_in[4][a] = ax_ff[3][a];
         ax_in[4][a].dr = ax_ff[3][a].diff * ax_ff[3][a].r;

         // Stage 5: mantissa.
         ax_in[5][a] = ax_ff[4][a];
         ax_in[5][a].mant = 33'(ax_ff[4][a].lo) + 33'(ax_ff[4][a].dr[61:30]);

         // Stage 6: size times mantissa.
         ax_in[6][a] = ax_ff[5][a];
         ax_in[6][a].hp = ax_ff[5][a].size * $signed({1'b0, ax_ff[5][a].mant});

         // Stage 7: scale by 2^n with rounding.
         ax_in[7][a] = ax_ff[6][a];
         sh = 7'(7'sd30 - 7'(ax_ff[6][a].n));
         magh = ax_ff[6][a].hp[49] ? 50'(-ax_ff[6][a].hp) : 50'(ax_ff[6][a].hp);
         rh = (magh + (50'(1) << (sh - 7'd1))) >> sh;
         ax_in[7][a].half = ax_ff[6][a].hp[49] ? -$signed(34'(rh)) : $signed(34'(rh));

         // Stage 8: corners, clamp to [0,1], max not below min.
         ax_in[8][a] = ax_ff[7][a];
         va = 35'(ax_ff[7][a].center) - 35'(ax_ff[7][a].half);
         vb = 35'(ax_ff[7][a].center) + 35'(ax_ff[7][a].half);
         ca = (35'(va) + 35'd1) >> 1;
         cb = (35'(vb) + 35'd1) >> 1;
         if (va < 0) oa = '0;
         else if (ca > 35'(abdd_pkg::COORD_ONE)) oa = abdd_pkg::COORD_ONE;
         else oa = 17'(ca);
         if (vb < 0) ob = '0;
         else if (cb > 35'(abdd_pkg::COORD_ONE)) ob = abdd_pkg::COORD_ONE;
         else ob = 17'(cb);
         if (oa > ob) ob = oa;
         ax_in[8][a].omin = oa[15:0];
         ax_in[8][a].omax = ob[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) begin
            ax_ff[k][0] <= ax_in[k][0];
            ax_ff[k][1] <= ax_in[k][1];
         end
      end
   end

   assign rsp_valid = valid_ff[NST-1];
   assign rsp_out_ymin = ax_ff[NST-1][0].omin;
   assign rsp_out_ymax = ax_ff[NST-1][0].omax;
   assign rsp_out_xmin = ax_ff[NST-1][1].omin;
   assign rsp_out_xmax = ax_ff[NST-1][1].omax;

endmodule

@@ src/abdd_checker.sv @@
module abdd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_out_ymin,
   input logic [15:0] rsp_out_xmin,
   input logic [15:0] rsp_out_ymax,
   input logic [15:0] rsp_out_xmax
);

   // Decoded boxes are never inverted.
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_ymax >= rsp_out_ymin) && (rsp_out_xmax >= rsp_out_xmin))
      else $error("decoded box is inverted");

   // The max corners lie in [0,1]; the min corners follow from a_order.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_ymax <= 16'd32768) && (rsp_out_xmax <= 16'd32768))
      else $error("decoded corner above 1.0");

   // A stalled beat holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_ymin) && $stable(rsp_out_xmin)
         && $stable(rsp_out_ymax) && $stable(rsp_out_xmax))
      else $error("stalled response changed");

   // The pipeline is empty after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind anchor_box_delta_decode_top abdd_checker u_abdd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_ymin (rsp_out_ymin),
   .rsp_out_xmin (rsp_out_xmin),
   .rsp_out_ymax (rsp_out_ymax),
   .rsp_out_xmax (rsp_out_xmax)
);

@@ tb/sv/tb_top.sv @@
module tb_top;

   localparam int TABLE_N = 256;
   localparam int PIPE_DEPTH = 9;
   localparam longint CLAMP_T = 64'sd10 <<< 23;
   localparam longint LOG2E_FX = 64'sd1549082005;
   localparam longint LN2_FX = 64'sd744261118;
   localparam longint ONE_FX = 64'sd1 <<< 30;
   localparam longint COORD_MAX = 64'sd32768;
   localparam logic [abdd_pkg::CSR_INDEX_W-1:0] REG_UNUSED_LO = 8'd4;
   localparam logic [abdd_pkg::CSR_INDEX_W-1:0] REG_UNUSED_HI = 8'd255;

   typedef struct packed {
      logic [abdd_pkg::COORD_W-1:0]        ymin;
      logic [abdd_pkg::COORD_W-1:0]        xmin;
      logic [abdd_pkg::COORD_W-1:0]        ymax;
      logic [abdd_pkg::COORD_W-1:0]        xmax;
      logic signed [abdd_pkg::DELTA_W-1:0] dcy;
      logic signed [abdd_pkg::DELTA_W-1:0] dcx;
      logic signed [abdd_pkg::DELTA_W-1:0] dh;
      logic signed [abdd_pkg::DELTA_W-1:0] dw;
   } box_req_type;

   typedef struct packed {
      logic [abdd_pkg::COORD_W-1:0] ymin;
      logic [abdd_pkg::COORD_W-1:0] xmin;
      logic [abdd_pkg::COORD_W-1:0] ymax;
      logic [abdd_pkg::COORD_W-1:0] xmax;
   } box_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   box_req_type req_box = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [abdd_pkg::COORD_W-1:0] rsp_out_ymin, rsp_out_xmin, rsp_out_ymax, rsp_out_xmax;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [abdd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [abdd_pkg::SCALE_W-1:0] csr_data = '0;

   longint pow2_lut [0:TABLE_N];
   logic [abdd_pkg::SCALE_W-1:0] scale_cy, scale_cx, scale_h, scale_w;
   box_rsp_type decoded_boxes[$];
   int mismatch_count = 0;
   bit quiet = 1'b0;
   int rsp_hold = 0;

   anchor_box_delta_decode_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_anchor_ymin(req_box.ymin), .req_anchor_xmin(req_box.xmin),
      .req_anchor_ymax(req_box.ymax), .req_anchor_xmax(req_box.xmax),
      .req_delta_cy(req_box.dcy), .req_delta_cx(req_box.dcx),
      .req_delta_h(req_box.dh), .req_delta_w(req_box.dw),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_ymin(rsp_out_ymin), .rsp_out_xmin(rsp_out_xmin),
      .rsp_out_ymax(rsp_out_ymax), .rsp_out_xmax(rsp_out_xmax),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Rounds v / 2^s to nearest, ties away from zero.
   function automatic longint round_shift(input longint v, input int s);
      longint half;
      half = 64'sd1 <<< (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
   endfunction

   function automatic longint scaled_delta(input logic signed [abdd_pkg::DELTA_W-1:0] d,
                                           input logic [abdd_pkg::SCALE_W-1:0] s);
      longint p;
      p = longint'(d) * longint'({48'd0, s});
      if (p > CLAMP_T) return CLAMP_T;
      if (p < -CLAMP_T) return -CLAMP_T;
      return p;
   endfunction

   // Half of size * exp(t) in Q.16, exp taken as 2^(t*log2 e) from the table.
   function automatic longint half_extent(input longint size, input longint t);
      longint u, n, f, idx, r, mant;
      u = round_shift(t * LOG2E_FX, 23);
      if (u >= 0) n = u >>> 30;
      else n = -((-u + ONE_FX - 1) >>> 30);
      f = u - n * ONE_FX;
      idx = (f * TABLE_N) >>> 30;
      r = (f * TABLE_N) & (ONE_FX - 1);
      if (idx > TABLE_N - 1) idx = TABLE_N - 1;
      mant = pow2_lut[idx] + (((pow2_lut[idx+1] - pow2_lut[idx]) * r) >>> 30);
      return round_shift(size * mant, 30 - int'(n));
   endfunction

   function automatic logic [abdd_pkg::COORD_W-1:0] clip_coord(input longint v);
      if (v < 0) return '0;
      if (v > COORD_MAX) return COORD_MAX[abdd_pkg::COORD_W-1:0];
      return v[abdd_pkg::COORD_W-1:0];
   endfunction

   function automatic void decode_axis(input logic [abdd_pkg::COORD_W-1:0] amin, amax,
                                       input logic signed [abdd_pkg::DELTA_W-1:0] dc,
                                       input logic [abdd_pkg::SCALE_W-1:0] sc,
                                       input logic signed [abdd_pkg::DELTA_W-1:0] ds,
                                       input logic [abdd_pkg::SCALE_W-1:0] ss,
                                       output logic [abdd_pkg::COORD_W-1:0] omin, omax);
      longint lo, hi, size, center, half;
      lo = longint'({48'd0, amin});
      hi = longint'({48'd0, amax});
      size = hi - lo;
      center = lo + hi + round_shift(scaled_delta(dc, sc) * size, 22);
      half = half_extent(size, scaled_delta(ds, ss));
      omin = clip_coord(round_shift(center - half, 1));
      omax = clip_coord(round_shift(center + half, 1));
      if (omin > omax) omax = omin;
   endfunction

   function automatic box_rsp_type decode_box(input box_req_type b);
      box_rsp_type o;
      decode_axis(b.ymin, b.ymax, b.dcy, scale_cy, b.dh, scale_h, o.ymin, o.ymax);
      decode_axis(b.xmin, b.xmax, b.dcx, scale_cx, b.dw, scale_w, o.xmin, o.xmax);
      return o;
   endfunction

   initial begin
      longint x, term, sum;
      for (int k = 0; k <= TABLE_N; k++) begin
         x = (longint'(k) * LN2_FX + TABLE_N / 2) / TABLE_N;
         term = ONE_FX;
         sum = ONE_FX;
         for (int i = 1; i <= 12; i++) begin
            term = ((term * x) >>> 30) / i;
            sum = sum + term;
         end
         pow2_lut[k] = sum;
      end
      scale_cy = abdd_pkg::SCALE_CENTER_RESET;
      scale_cx = abdd_pkg::SCALE_CENTER_RESET;
      scale_h = abdd_pkg::SCALE_SIZE_RESET;
      scale_w = abdd_pkg::SCALE_SIZE_RESET;
   end

   // Response side back-pressure in short random bursts.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      box_rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_ymin, rsp_out_xmin, rsp_out_ymax, rsp_out_xmax};
         if (decoded_boxes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response beat %h", got);
         end else begin
            want = decoded_boxes.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"box mismatch: expected ymin %0d xmin %0d ymax %0d xmax %0d,",
                            " got %0d %0d %0d %0d"},
                           want.ymin, want.xmin, want.ymax, want.xmax,
                           got.ymin, got.xmin, got.ymax, got.xmax);
            end
         end
      end
   end

   task automatic send_box(input box_req_type b);
      req_valid <= 1'b1;
      req_box <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decoded_boxes.push_back(decode_box(b));
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_boxes.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 3) @(posedge clock);
   endtask

   task automatic write_scale(input logic [abdd_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [abdd_pkg::SCALE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         abdd_pkg::REG_SCALE_CENTER_Y: scale_cy = val;
         abdd_pkg::REG_SCALE_CENTER_X: scale_cx = val;
         abdd_pkg::REG_SCALE_HEIGHT:   scale_h = val;
         abdd_pkg::REG_SCALE_WIDTH:    scale_w = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_scales(input logic [abdd_pkg::SCALE_W-1:0] cy, cx, h, w);
      wait_idle();
      write_scale(abdd_pkg::REG_SCALE_CENTER_Y, cy);
      write_scale(abdd_pkg::REG_SCALE_CENTER_X, cx);
      write_scale(abdd_pkg::REG_SCALE_HEIGHT, h);
      write_scale(abdd_pkg::REG_SCALE_WIDTH, w);
   endtask

   function automatic box_req_type random_box();
      box_req_type b;
      int lo, hi;
      if ($urandom_range(0, 4) == 0) begin
         b = {$urandom, $urandom, $urandom, $urandom};
      end else begin
         lo = $urandom_range(0, 30000);
         hi = $urandom_range(lo, 32768);
         b.ymin = 16'(lo); b.ymax = 16'(hi);
         lo = $urandom_range(0, 30000);
         hi = $urandom_range(lo, 32768);
         b.xmin = 16'(lo); b.xmax = 16'(hi);
         b.dcy = 16'($urandom_range(0, 8191) - 4096);
         b.dcx = 16'($urandom_range(0, 8191) - 4096);
         b.dh = 16'($urandom_range(0, 8191) - 4096);
         b.dw = 16'($urandom_range(0, 8191) - 4096);
      end
      return b;
   endfunction

   task automatic test_directed();
      box_req_type b;
      send_box('{16'd0, 16'd0, 16'd32768, 16'd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      send_box('{16'd8192, 16'd4096, 16'd16384, 16'd20000, 16'sd2048, -16'sd2048,
                 16'sd1024, -16'sd1024});
      send_box('{16'd0, 16'd0, 16'd32768, 16'd32768, 16'sh7fff, 16'sh7fff,
                 16'sh7fff, 16'sh7fff});
      send_box('{16'd0, 16'd0, 16'd32768, 16'd32768, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh8000});
      // Inverted anchors keep their negative size.
      send_box('{16'd30000, 16'd20000, 16'd1000, 16'd5000, 16'sd500, -16'sd700,
                 16'sd300, -16'sd900});
      // Coordinates above 1.0 are taken as they are.
      send_box('{16'hffff, 16'h9000, 16'hffff, 16'hffff, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      send_box('{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'sh8000, 16'sh7fff,
                 16'sh7fff, 16'sh8000});
      send_box('{16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'sd4000, 16'sd4000,
                 16'sd4000, 16'sd4000});
      send_box('{16'd32768, 16'd32768, 16'd0, 16'd0, 16'sh7fff, 16'sh8000,
                 16'sh8000, 16'sh7fff});
      for (int i = 0; i < 6; i++) begin
         b = random_box();
         send_box(b);
      end
   endtask

   task automatic test_scale_extremes();
      box_req_type b;
      // A zero scale cancels the delta entirely.
      set_scales(16'd0, 16'd0, 16'd0, 16'd0);
      send_box('{16'd1000, 16'd2000, 16'd9000, 16'd30000, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh8000});
      send_box('{16'd0, 16'd0, 16'd32768, 16'd32768, 16'sd1, 16'sd1, 16'sd1, 16'sd1});
      set_scales(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_box('{16'd10000, 16'd10000, 16'd12000, 16'd11000, 16'sd1, -16'sd1,
                 16'sd1, -16'sd1});
      send_box('{16'd0, 16'd0, 16'd32768, 16'd32768, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh8000});
      // Writes to unused indexes must leave the scales alone.
      wait_idle();
      write_scale(REG_UNUSED_LO, 16'd1234);
      write_scale(REG_UNUSED_HI, 16'd0);
      for (int i = 0; i < 4; i++) begin
         b = random_box();
         send_box(b);
      end
   endtask

   task automatic test_random_stream();
      box_req_type b;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0)
            set_scales(abdd_pkg::SCALE_CENTER_RESET, abdd_pkg::SCALE_CENTER_RESET,
                       abdd_pkg::SCALE_SIZE_RESET, abdd_pkg::SCALE_SIZE_RESET);
         else
            set_scales(16'($urandom), 16'($urandom_range(0, 4096)),
                       16'($urandom_range(0, 8192)), 16'($urandom));
         if (phase == 5) quiet = 1'b1;
         for (int i = 0; i < 220; i++) begin
            b = random_box();
            send_box(b);
            if (phase == 2 && i == 100) wait_idle();
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_scale_extremes();
      test_random_stream();
      wait_idle();
      if (mismatch_count == 0 && decoded_boxes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
src/abdd_pkg.sv
src/anchor_box_delta_decode_top.sv
src/abdd_checker.sv
tb/sv/tb_top.sv
